### design/sfe_pkg.sv
package sfe_pkg;

    // field widths
    localparam int SAMPLE_W = 24;
    localparam int DELAY_W  = 17;
    localparam int GAIN_W   = 16;
    localparam int CFG_W    = 17;

    // configuration register indexes
    localparam logic [1:0] REG_DELAY_SAMPLES = 2'd0;
    localparam logic [1:0] REG_FEEDBACK_GAIN = 2'd1;
    localparam logic [1:0] REG_WET_LEVEL     = 2'd2;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
    localparam logic [GAIN_W-1:0]  WET_RESET   = 16'd0;

    // longest usable delay in samples
    localparam logic [DELAY_W-1:0] MAX_DELAY = 17'd95999;

    // one-pole smoother coefficients, 0.99 and 0.01 in q0.16
    localparam logic [15:0] SMOOTH_KEEP = 16'd64881;
    localparam logic [9:0]  SMOOTH_TAKE = 10'd655;

    // unity in q1.23
    localparam logic [24:0] ONE_Q23 = 25'd8388608;

    localparam logic signed [31:0] SAT_HI = 32'sd8388607;
    localparam logic signed [31:0] SAT_LO = -32'sd8388608;

    // per-step commands from the sequencer
    typedef struct packed {
        logic load_in;
        logic mod_step;
        logic addr_step;
        logic fb_mul;
        logic fb_wr;
        logic mix_mul;
        logic out_load;
    } sfe_cmd_t;

    // status back to the sequencer
    typedef struct packed {
        logic out_free;
    } sfe_status_t;

    // clamp to the signed 24-bit range
    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [31:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[SAMPLE_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[SAMPLE_W-1:0];
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/sfe_ram.sv
module sfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // single write port, registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/sfe_ctrl.sv
module sfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  sfe_pkg::sfe_status_t status,
    output sfe_pkg::sfe_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MOD  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_FB   = 3'd4;
    localparam logic [2:0] ST_MIX  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // sequence one beat through the datapath steps
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MOD;
                end
            end
            ST_MOD: begin
                cmd.mod_step = 1'b1;
                state_next   = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.addr_step = 1'b1;
                state_next    = ST_READ;
            end
            ST_READ: begin
                cmd.fb_mul = 1'b1;
                state_next = ST_FB;
            end
            ST_FB: begin
                cmd.fb_wr  = 1'b1;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix_mul = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // at most one step per cycle
    a_one_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath step in a cycle");

    // an accepted beat starts the modulo step next
    a_load_then_mod: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_in |=> cmd.mod_step)
        else $error("accepted beat not followed by modulo step");

    // result register only loaded when it can take a value
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending beat");

endmodule

### design/sfe_datapath.sv
module sfe_datapath #(
    parameter int DEPTH = 131072
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [sfe_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic [sfe_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic [0:0]                   s_tuser,
    input  logic                         m_tready,
    output logic                         m_tvalid,
    output logic [sfe_pkg::SAMPLE_W-1:0] m_tdata,
    input  sfe_pkg::sfe_cmd_t            cmd,
    output sfe_pkg::sfe_status_t         status
);

    localparam int AW = $clog2(DEPTH);
    localparam int MW = (AW + 1 > sfe_pkg::DELAY_W) ? AW + 1 : sfe_pkg::DELAY_W;
    localparam int K  = sfe_pkg::DELAY_W + AW;
    localparam longint unsigned RECIP = (64'd1 << K) / DEPTH;

    localparam logic [18:0]   RECIP_W  = 19'(RECIP);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [MW-1:0] DEPTH_M  = MW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // configuration registers
    logic [sfe_pkg::DELAY_W-1:0] delay_reg;
    logic [sfe_pkg::GAIN_W-1:0]  gain_reg;
    logic [sfe_pkg::GAIN_W-1:0]  wet_reg;

    // channel state
    logic [AW-1:0] widx_reg [2];
    logic [1:0]    wrapped_reg;
    logic [23:0]   smooth_reg;
    logic [23:0]   smooth_next;

    // per-beat registers
    logic signed [sfe_pkg::SAMPLE_W-1:0] x_reg;
    logic                                ch_reg;
    logic [AW-1:0]                       w_reg;
    logic [sfe_pkg::DELAY_W-1:0]         d_clamp_reg;
    logic [35:0]                         prod_d_reg;
    logic [sfe_pkg::DELAY_W-1:0]         qd_reg;
    logic [39:0]                         p_keep_reg;
    logic [33:0]                         p_take_reg;
    logic                                rvalid_reg;
    logic signed [40:0]                  prod_fb_reg;
    logic signed [sfe_pkg::SAMPLE_W-1:0] v_reg;
    logic signed [48:0]                  prod_dry_reg;
    logic signed [48:0]                  prod_wet_reg;
    logic                                m_tvalid_reg;
    logic [sfe_pkg::SAMPLE_W-1:0]        m_tdata_reg;

    logic [sfe_pkg::DELAY_W-1:0] d_clamp;
    logic [sfe_pkg::DELAY_W-1:0] quot;
    logic [sfe_pkg::DELAY_W-1:0] rem_raw;
    logic [MW-1:0]               rem_m;
    logic [MW-1:0]               rem_fix;
    logic [AW-1:0]               rem_a;
    logic [AW:0]                 rd_full;
    logic [AW-1:0]               rd_idx;
    logic                        rvalid_next;
    logic [AW:0]                 ram_raddr;
    logic [AW:0]                 ram_waddr;
    logic [sfe_pkg::SAMPLE_W-1:0] ram_rdata;
    logic signed [sfe_pkg::SAMPLE_W-1:0] delayed;
    logic signed [24:0]          fb_sum;
    logic signed [40:0]          fb_round;
    logic signed [40:0]          fb_shift;
    logic signed [sfe_pkg::SAMPLE_W-1:0] v_next;
    logic [40:0]                 smooth_sum;
    logic signed [24:0]          dry_coef;
    logic signed [49:0]          mix_sum;
    logic signed [49:0]          mix_shift;
    logic signed [sfe_pkg::SAMPLE_W-1:0] y_next;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg <= sfe_pkg::DELAY_RESET;
            gain_reg  <= sfe_pkg::GAIN_RESET;
            wet_reg   <= sfe_pkg::WET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfe_pkg::REG_DELAY_SAMPLES: delay_reg <= cfg_wr_data;
                sfe_pkg::REG_FEEDBACK_GAIN: gain_reg  <= cfg_wr_data[sfe_pkg::GAIN_W-1:0];
                sfe_pkg::REG_WET_LEVEL:     wet_reg   <= cfg_wr_data[sfe_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // delay clamp and reduction modulo the store depth via reciprocal
    assign d_clamp = (delay_reg > sfe_pkg::MAX_DELAY) ? sfe_pkg::MAX_DELAY : delay_reg;
    assign quot    = sfe_pkg::DELAY_W'(prod_d_reg >> K);
    assign rem_raw = d_clamp_reg - qd_reg;
    assign rem_m   = MW'(rem_raw);
    assign rem_fix = (rem_m >= DEPTH_M) ? rem_m - DEPTH_M : rem_m;
    assign rem_a   = AW'(rem_fix);

    // read index behind the write index, with wrap
    assign rd_full = (w_reg >= rem_a) ? {1'b0, w_reg} - {1'b0, rem_a}
                                      : {1'b0, w_reg} + DEPTH_W - {1'b0, rem_a};
    assign rd_idx  = AW'(rd_full);

    // entries not yet written since reset read as zero
    assign rvalid_next = wrapped_reg[ch_reg] || (rd_idx < w_reg);

    // each channel owns one half of the store
    assign ram_raddr = ch_reg ? {1'b0, rd_idx} + DEPTH_W : {1'b0, rd_idx};
    assign ram_waddr = ch_reg ? {1'b0, w_reg} + DEPTH_W : {1'b0, w_reg};

    // feedback path
    assign delayed  = rvalid_reg ? $signed(ram_rdata) : '0;
    assign fb_sum   = 25'(x_reg) + 25'(delayed);
    assign fb_round = prod_fb_reg + 41'sd16384;
    assign fb_shift = fb_round >>> 15;
    assign v_next   = sfe_pkg::sat24(32'(fb_shift));

    // wet level smoother
    assign smooth_sum  = 41'(p_keep_reg) + 41'(p_take_reg) + 41'd32768;
    assign smooth_next = 24'(smooth_sum >> 16);

    // dry and wet mix
    assign dry_coef  = $signed(sfe_pkg::ONE_Q23 - {1'b0, smooth_reg});
    assign mix_sum   = 50'(prod_dry_reg) + 50'(prod_wet_reg) + 50'sd4194304;
    assign mix_shift = mix_sum >>> 23;
    assign y_next    = sfe_pkg::sat24(32'(mix_shift));

    sfe_ram #(
        .WIDTH(sfe_pkg::SAMPLE_W),
        .DEPTH(2 * DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.fb_wr),
        .wr_addr (ram_waddr),
        .wr_data (v_next),
        .rd_en   (cmd.addr_step),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // per-beat payload pipeline
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            x_reg       <= $signed(s_tdata);
            ch_reg      <= s_tuser[0];
            w_reg       <= widx_reg[s_tuser[0]];
            d_clamp_reg <= d_clamp;
            prod_d_reg  <= 36'(d_clamp) * 36'(RECIP_W);
        end
        if (cmd.mod_step) begin
            qd_reg     <= sfe_pkg::DELAY_W'(36'(quot) * 36'(DEPTH_W));
            p_keep_reg <= 40'(sfe_pkg::SMOOTH_KEEP) * 40'(smooth_reg);
            p_take_reg <= 34'(sfe_pkg::SMOOTH_TAKE) * 34'({wet_reg, 8'h00});
        end
        if (cmd.addr_step) begin
            rvalid_reg <= rvalid_next;
        end
        if (cmd.fb_mul) begin
            prod_fb_reg <= 41'(fb_sum) * 41'($signed({1'b0, gain_reg}));
        end
        if (cmd.fb_wr) begin
            v_reg <= v_next;
        end
        if (cmd.mix_mul) begin
            prod_dry_reg <= 49'(x_reg) * 49'(dry_coef);
            prod_wet_reg <= 49'(v_reg) * 49'($signed({1'b0, smooth_reg}));
        end
        if (cmd.out_load) begin
            m_tdata_reg <= y_next;
        end
    end

    // channel state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            widx_reg[0]  <= '0;
            widx_reg[1]  <= '0;
            wrapped_reg  <= '0;
            smooth_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.addr_step) begin
                smooth_reg <= smooth_next;
            end
            if (cmd.fb_wr) begin
                if (w_reg == LAST_IDX) begin
                    widx_reg[ch_reg]    <= '0;
                    wrapped_reg[ch_reg] <= 1'b1;
                end else begin
                    widx_reg[ch_reg] <= w_reg + AW'(1);
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_free = !m_tvalid_reg || m_tready;

    // write indexes never leave the store
    a_widx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, widx_reg[0]} < DEPTH_W) && ({1'b0, widx_reg[1]} < DEPTH_W))
        else $error("write index beyond store depth");

endmodule

### design/stereo_feedback_echo.sv
// Stereo feedback echo with a smoothed wet/dry mix.
//
// Input channel s_*: one beat per audio sample, s_tdata holds the signed
// q1.23 sample, s_tuser selects the channel (0 left, 1 right).
// Result channel m_*: one beat per input beat, the saturated q1.23 mix.
// Configuration: a write at cfg_wr_en sets register cfg_index (0 delay in
// samples, 1 feedback gain q1.15, 2 target wet level q1.15); write only
// while no beat is in flight.
//
// A beat is taken only when the previous one has reached the output
// register: the per-sample chain of delay reduction, one read of the
// shared delay store, the feedback multiply, its write back and the mix
// multiplies runs through one datapath in sequence.
// A result waits in the output register while the receiver stalls; the
// next input beat is still taken and runs until its own result is ready.
// Reset clears the write indexes, wet smoother and m_tvalid and loads the
// configuration defaults; per-channel wrap flags make unwritten entries
// read as zero: no clearing pass, beats are taken right after reset.
module stereo_feedback_echo #(
    parameter int DEPTH = 131072
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [1:0]                   cfg_index,
    input  logic [sfe_pkg::CFG_W-1:0]    cfg_wr_data,
    // input samples
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [sfe_pkg::SAMPLE_W-1:0] s_tdata,   // [23:0] sample_in
    input  logic [0:0]                   s_tuser,   // [0] channel
    // output samples
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [sfe_pkg::SAMPLE_W-1:0] m_tdata    // [23:0] sample_out
);

    sfe_pkg::sfe_cmd_t    cmd;
    sfe_pkg::sfe_status_t status;

    sfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sfe_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

### tb/tb_stereo_feedback_echo.sv
`timescale 1ns / 100ps

module tb_stereo_feedback_echo;

    localparam int ECHO_DEPTH   = 131072;
    localparam int HALF_PERIOD  = 6;
    localparam int DRAIN_CYCLES = 14;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 55;

    localparam logic signed [sfe_pkg::SAMPLE_W-1:0] PEAK_POS = 24'sh7FFFFF;
    localparam logic signed [sfe_pkg::SAMPLE_W-1:0] PEAK_NEG = 24'sh800000;
    localparam logic [sfe_pkg::CFG_W-1:0] UNITY_Q15 = 17'd32768;
    localparam logic [sfe_pkg::CFG_W-1:0] GAIN_FULL = 17'd65535;
    localparam logic [sfe_pkg::CFG_W-1:0] DELAY_TOP = 17'd131071;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = sfe_pkg::REG_DELAY_SAMPLES;
    logic [sfe_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [sfe_pkg::SAMPLE_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [sfe_pkg::SAMPLE_W-1:0] m_tdata;

    // echo state mirrored by the predictor
    int echo_mem [2][ECHO_DEPTH];
    int wr_ptr [2];
    longint wet_smooth;
    int cur_delay;
    longint cur_gain;
    longint cur_wet;

    logic [sfe_pkg::SAMPLE_W-1:0] pending_mix [$];
    int mismatches = 0;
    int quiet_cycles = 0;
    bit tx_gaps_on = 1'b1;
    bit rx_gaps_on = 1'b1;

    stereo_feedback_echo #(
        .DEPTH(ECHO_DEPTH)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),   // [23:0] sample_in
        .s_tuser(s_tuser),   // [0] channel
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)    // [23:0] sample_out
    );

    always #HALF_PERIOD aclk = ~aclk;

    // clamp to the signed q1.23 range
    function automatic longint clamp24(input longint v);
        if (v > longint'(sfe_pkg::SAT_HI)) begin
            return longint'(sfe_pkg::SAT_HI);
        end else if (v < longint'(sfe_pkg::SAT_LO)) begin
            return longint'(sfe_pkg::SAT_LO);
        end
        return v;
    endfunction

    // one echo step: delayed read, feedback write, smoother update, wet/dry mix
    function automatic logic [sfe_pkg::SAMPLE_W-1:0] echo_predict(
        input logic signed [sfe_pkg::SAMPLE_W-1:0] x,
        input logic ch
    );
        int d;
        int w;
        int r;
        longint fb;
        longint v;
        longint mix;
        longint y;
        d = cur_delay;
        if (d > int'(sfe_pkg::MAX_DELAY)) begin
            d = int'(sfe_pkg::MAX_DELAY);
        end
        d = d % ECHO_DEPTH;
        w = wr_ptr[ch];
        r = (w >= d) ? (w - d) : (w + ECHO_DEPTH - d);
        fb = (longint'(x) + longint'(echo_mem[ch][r])) * cur_gain;
        v = clamp24((fb + (longint'(1) <<< 14)) >>> 15);
        echo_mem[ch][w] = int'(v);
        wr_ptr[ch] = (w + 1 == ECHO_DEPTH) ? 0 : w + 1;
        wet_smooth = (longint'(sfe_pkg::SMOOTH_KEEP) * wet_smooth
                      + longint'(sfe_pkg::SMOOTH_TAKE) * (cur_wet <<< 8) + 32768) >>> 16;
        mix = longint'(x) * (longint'(sfe_pkg::ONE_Q23) - wet_smooth) + v * wet_smooth;
        y = clamp24((mix + (longint'(1) <<< 22)) >>> 23);
        return y[sfe_pkg::SAMPLE_W-1:0];
    endfunction

    // register write, mirrored into the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [sfe_pkg::CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            sfe_pkg::REG_DELAY_SAMPLES: cur_delay = int'(val[sfe_pkg::DELAY_W-1:0]);
            sfe_pkg::REG_FEEDBACK_GAIN: cur_gain = longint'(val[sfe_pkg::GAIN_W-1:0]);
            sfe_pkg::REG_WET_LEVEL:     cur_wet = longint'(val[sfe_pkg::GAIN_W-1:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_echo(input logic [sfe_pkg::CFG_W-1:0] delay,
                            input logic [sfe_pkg::CFG_W-1:0] gain,
                            input logic [sfe_pkg::CFG_W-1:0] wet);
        write_reg(sfe_pkg::REG_DELAY_SAMPLES, delay);
        write_reg(sfe_pkg::REG_FEEDBACK_GAIN, gain);
        write_reg(sfe_pkg::REG_WET_LEVEL, wet);
    endtask

    // one input beat; returns at the falling edge after acceptance
    task automatic send_sample(input logic signed [sfe_pkg::SAMPLE_W-1:0] x, input logic ch);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tuser <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_mix.push_back(echo_predict(x, ch));
        @(negedge aclk);
    endtask

    // stop sending and let every result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_mix.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic logic signed [sfe_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return PEAK_POS;
            1: return PEAK_NEG;
            2: return sfe_pkg::SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
            default: return sfe_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [sfe_pkg::CFG_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return sfe_pkg::MAX_DELAY;
            2: return sfe_pkg::CFG_W'($urandom_range(96000, 131071));
            default: return sfe_pkg::CFG_W'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [sfe_pkg::CFG_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return UNITY_Q15;
            2: return sfe_pkg::CFG_W'($urandom_range(32769, 65535));
            default: return sfe_pkg::CFG_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // default registers: zero delay reads unwritten entries as zero, no wet signal
    task automatic test_reset_passthrough();
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_NEG, 1'b1);
        send_sample('0, 1'b0);
        send_sample(-24'sd1, 1'b1);
        send_sample(24'sd1, 1'b0);
        send_sample(PEAK_POS, 1'b1);
        drain_results();
    endtask

    // one-sample echo at unity gain, feedback saturates
    task automatic test_short_delay_feedback();
        set_echo(17'd1, UNITY_Q15, UNITY_Q15);
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_NEG, 1'b1);
        send_sample(PEAK_NEG, 1'b1);
        send_sample(24'sd12345, 1'b0);
        drain_results();
    endtask

    // delay beyond the clamp, gain and wet level above one
    task automatic test_delay_clamp_overgain();
        set_echo(DELAY_TOP, GAIN_FULL, GAIN_FULL);
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_NEG, 1'b1);
        send_sample(-24'sd1, 1'b0);
        send_sample(24'sd4000000, 1'b1);
        drain_results();
        write_reg(sfe_pkg::REG_DELAY_SAMPLES, sfe_pkg::MAX_DELAY);
        send_sample(PEAK_NEG, 1'b0);
        send_sample(24'sd777, 1'b1);
        drain_results();
    endtask

    // no feedback at all, half wet
    task automatic test_zero_gain();
        set_echo('0, '0, 17'd16384);
        send_sample(PEAK_POS, 1'b0);
        send_sample(PEAK_NEG, 1'b1);
        send_sample(24'sd100000, 1'b0);
        send_sample(-24'sd100000, 1'b1);
        drain_results();
    endtask

    // random settings per phase, random samples and idling
    task automatic test_random_traffic();
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            if (ph == 0) begin
                set_echo(17'd3, 17'd24000, 17'd20000);
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end else begin
                set_echo(pick_delay(), pick_level(), pick_level());
                tx_gaps_on = (ph == 1) || ($urandom_range(0, 3) != 0);
                rx_gaps_on = (ph == 1) || ($urandom_range(0, 3) != 0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_sample(pick_sample(), 1'($urandom_range(0, 1)));
                // sender holds off until everything is back
                if (ph == 4 && i == PHASE_ITEMS / 2) begin
                    drain_results();
                end
            end
            drain_results();
        end
    endtask

    // result side: random stalls, compare each beat with the oldest prediction
    initial begin
        int stall;
        logic [sfe_pkg::SAMPLE_W-1:0] want;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            stall = rx_gaps_on ? $urandom_range(0, 11) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (pending_mix.size() == 0) begin
                $display("%0t: result beat with nothing expected, got %0d",
                         $time, $signed(m_tdata));
                mismatches++;
            end else begin
                want = pending_mix.pop_front();
                if (m_tdata !== want) begin
                    $display("%0t: sample_out mismatch, expected %0d, got %0d",
                             $time, $signed(want), $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
                $display("tb_stereo_feedback_echo NOT OK");
                $finish;
            end
        end
    end

    initial begin
        // predictor starts from the reset state
        wr_ptr[0] = 0;
        wr_ptr[1] = 0;
        wet_smooth = 0;
        cur_delay = int'(sfe_pkg::DELAY_RESET);
        cur_gain = longint'(sfe_pkg::GAIN_RESET);
        cur_wet = longint'(sfe_pkg::WET_RESET);
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_passthrough();
        test_short_delay_feedback();
        test_delay_clamp_overgain();
        test_zero_gain();
        test_random_traffic();
        drain_results();
        if (mismatches == 0) begin
            $display("tb_stereo_feedback_echo OK");
        end else begin
            $display("tb_stereo_feedback_echo NOT OK");
        end
        $finish;
    end

endmodule

### sim.f
design/sfe_pkg.sv
design/sfe_ram.sv
design/sfe_ctrl.sv
design/sfe_datapath.sv
design/stereo_feedback_echo.sv
tb/tb_stereo_feedback_echo.sv
